FILE: rtl/cds_pkg.sv
`default_nettype none

package cds_pkg;

  localparam int CMD_W       = 2;
  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  localparam int STATUS_W    = 2;
  localparam int STEP_DAYS_W = 16;
  localparam int MOD400_W    = 9;

  localparam int STEP_WIDTH_DEFAULT = 16;
  localparam int YEAR_LIMIT_DEFAULT = 10000;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FWD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BWD  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_LOAD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CLAMPED  = 2'd2;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] DAY_LAST  = 5'd31;

  localparam int LEAP_CYCLE = 400;

  // Held date plus the year modulo 400, kept alongside so the leap rule
  // needs no divider.
  typedef struct packed {
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [MOD400_W-1:0] mod400;
  } date_t;

  typedef struct packed {
    logic finish;
    logic clamped;
  } step_flags_t;

  function automatic logic is_leap(input logic [MOD400_W-1:0] m);
    logic by_four;
    logic century;
    by_four = (m[1:0] == 2'd0);
    century = (m == 9'd100) || (m == 9'd200) || (m == 9'd300);
    return by_four && !century;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cds_req_if.sv
`default_nettype none

interface cds_req_if import cds_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [DAY_W-1:0]       load_day;
  logic [MONTH_W-1:0]     load_month;
  logic [YEAR_W-1:0]      load_year;
  logic [STEP_DAYS_W-1:0] step_days;

  modport source (output valid, cmd, load_day, load_month, load_year, step_days,
                  input ready);
  modport sink   (input valid, cmd, load_day, load_month, load_year, step_days,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/cds_rsp_if.sv
`default_nettype none

interface cds_rsp_if import cds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DAY_W-1:0]    out_day;
  logic [MONTH_W-1:0]  out_month;
  logic [YEAR_W-1:0]   out_year;
  logic [STATUS_W-1:0] status;

  modport source (output valid, out_day, out_month, out_year, status, input ready);
  modport sink   (input valid, out_day, out_month, out_year, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/calendar_date_stepper_core.sv
`default_nettype none

// Calendar date stepper. Holds one Gregorian date (reset: 1 January of year 1)
// and takes one request word at a time: load a date, or move it forward or
// backward by step_days days. Each request gives one response word with the
// held date after the step and a status (ok, load rejected, clamped at the
// year limits). The block takes no request while one is in progress. A load
// goes through its steps in order: a reciprocal multiply gives the year
// divided by 400, one subtract gives the year modulo 400 for the leap rule,
// then a check state. A move walks one month per cycle through the shared
// month step unit; a clamped move stops early. An unused command answers
// with the held date. The response sits in an output register, so the next
// request may be accepted while the previous response still waits.
module calendar_date_stepper_core import cds_pkg::*; #(
  parameter int STEP_WIDTH = STEP_WIDTH_DEFAULT,
  parameter int YEAR_LIMIT = YEAR_LIMIT_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  cds_req_if.sink   req,
  cds_rsp_if.source rsp
);

  // Only the low bits of step_days that fit both the port and STEP_WIDTH count.
  localparam int LEFT_W = (STEP_WIDTH < STEP_DAYS_W) ? STEP_WIDTH : STEP_DAYS_W;

  // Year over 400 by a reciprocal multiply; exact for every year the load
  // port can carry.
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_400   = ((1 << RECIP_SHIFT) + LEAP_CYCLE - 1) / LEAP_CYCLE;
  localparam int QUO_W       = $clog2(((1 << YEAR_W) - 1) / LEAP_CYCLE + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;
  localparam logic [2:0] ST_REM  = 3'd5;

  logic [2:0]          state;
  date_t               cur;
  logic                backward;
  logic [LEFT_W-1:0]   left;
  logic [STATUS_W-1:0] status_r;

  logic [DAY_W-1:0]    ld_day;
  logic [MONTH_W-1:0]  ld_month;
  logic [YEAR_W-1:0]   ld_year;
  logic [QUO_W-1:0]    quo;
  logic [MOD400_W-1:0] rem;

  date_t               cur_next;
  logic [LEFT_W-1:0]   left_next;
  step_flags_t         flags;

  logic [QUO_W-1:0]    quo_calc;
  logic [YEAR_W-1:0]   quo_x400;
  logic [DAY_W-1:0]    ld_len;
  logic                ld_valid;

  cds_step_unit #(
    .LEFT_W     (LEFT_W),
    .YEAR_LIMIT (YEAR_LIMIT)
  ) u_step (
    .cur       (cur),
    .backward  (backward),
    .left      (left),
    .nxt       (cur_next),
    .left_next (left_next),
    .flags     (flags)
  );

  assign req.ready = (state == ST_IDLE);

  // Reciprocal quotient, remainder product and load check.
  always_comb begin
    quo_calc = QUO_W'(((2*YEAR_W)'(ld_year) * (2*YEAR_W)'(RECIP_400)) >> RECIP_SHIFT);
    quo_x400 = YEAR_W'(quo) * YEAR_W'(LEAP_CYCLE);
    ld_len   = month_len(ld_month, is_leap(rem));
    ld_valid = (ld_len != '0) && (ld_day != '0) && (ld_day <= ld_len) &&
               (ld_year != '0) && (ld_year <= YEAR_W'(YEAR_LIMIT));
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur.day    <= DAY_FIRST;
      cur.month  <= MONTH_JAN;
      cur.year   <= YEAR_W'(1);
      cur.mod400 <= MOD400_W'(1);
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            ld_day   <= req.load_day;
            ld_month <= req.load_month;
            ld_year  <= req.load_year;
            left     <= req.step_days[LEFT_W-1:0];
            backward <= (req.cmd == CMD_BWD);
            status_r <= STATUS_OK;
            case (req.cmd)
              CMD_LOAD:         state <= ST_DIV;
              CMD_FWD, CMD_BWD: state <= ST_WALK;
              default:          state <= ST_DONE;
            endcase
          end
        end
        ST_DIV: begin
          // Hold the year over 400.
          quo   <= quo_calc;
          state <= ST_REM;
        end
        ST_REM: begin
          // Drop 400 times the quotient to leave the year modulo 400.
          rem   <= MOD400_W'(ld_year - quo_x400);
          state <= ST_CHK;
        end
        ST_CHK: begin
          // Commit a good load; keep the held date on a bad one.
          if (ld_valid) begin
            cur.day    <= ld_day;
            cur.month  <= ld_month;
            cur.year   <= ld_year;
            cur.mod400 <= rem;
            status_r   <= STATUS_OK;
          end else begin
            status_r   <= STATUS_BAD_LOAD;
          end
          state <= ST_DONE;
        end
        ST_WALK: begin
          // Advance one month per cycle until the count runs out or the move clamps.
          cur  <= cur_next;
          left <= left_next;
          if (flags.finish) begin
            status_r <= flags.clamped ? STATUS_CLAMPED : STATUS_OK;
            state    <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold here until the output register is free.
          if (!rsp.valid || rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.out_day   <= cur.day;
      rsp.out_month <= cur.month;
      rsp.out_year  <= cur.year;
      rsp.status    <= status_r;
    end
  end

  // The held date stays a real date inside the year range.
  a_date_valid: assert property (@(posedge clk) disable iff (rst)
    (cur.day != '0) && (cur.day <= month_len(cur.month, is_leap(cur.mod400))))
    else $error("held day outside its month");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    (cur.year >= YEAR_W'(1)) && (cur.year <= YEAR_W'(YEAR_LIMIT)))
    else $error("held year outside range");

  a_mod_track: assert property (@(posedge clk) disable iff (rst)
    cur.mod400 < MOD400_W'(LEAP_CYCLE))
    else $error("year modulo 400 out of range");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_DONE)
    else $error("response raised outside done state");

  a_walk_month_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && !flags.finish) |=>
      (cur.day == DAY_FIRST) || (cur.day >= 5'd28))
    else $error("month crossing left a middle day");

endmodule

`default_nettype wire

FILE: rtl/cds_step_unit.sv
`default_nettype none

// One month of a move: either finish inside the current month or cross
// into the next (or previous) month, clamping at the year limits.
module cds_step_unit import cds_pkg::*; #(
  parameter int LEFT_W     = STEP_WIDTH_DEFAULT,
  parameter int YEAR_LIMIT = YEAR_LIMIT_DEFAULT
) (
  input  date_t             cur,
  input  logic              backward,
  input  logic [LEFT_W-1:0] left,
  output date_t             nxt,
  output logic [LEFT_W-1:0] left_next,
  output step_flags_t       flags
);

  localparam int CW = (LEFT_W > 6) ? LEFT_W : 6;
  localparam logic [MOD400_W-1:0] LIMIT_MOD = MOD400_W'(YEAR_LIMIT % LEAP_CYCLE);
  localparam logic [MOD400_W-1:0] MOD_LAST  = MOD400_W'(LEAP_CYCLE - 1);

  logic [DAY_W-1:0]   ml;
  logic [DAY_W-1:0]   ml_prev;
  logic [DAY_W-1:0]   room;
  logic [MONTH_W-1:0] prev_month;
  logic [CW-1:0]      left_ext;

  always_comb begin
    ml         = month_len(cur.month, is_leap(cur.mod400));
    prev_month = cur.month - MONTH_W'(1);
    ml_prev    = month_len(prev_month, is_leap(cur.mod400));
    room       = ml - cur.day;
    left_ext   = CW'(left);
    nxt        = cur;
    left_next  = left;
    flags      = '0;
    if (!backward) begin
      if (left_ext <= CW'(room)) begin
        nxt.day      = cur.day + left_ext[DAY_W-1:0];
        flags.finish = 1'b1;
      end else begin
        left_next = LEFT_W'(left_ext - CW'(room) - CW'(1));
        nxt.day   = DAY_FIRST;
        if (cur.month == MONTH_DEC) begin
          if (cur.year >= YEAR_W'(YEAR_LIMIT)) begin
            nxt.day       = DAY_LAST;
            nxt.month     = MONTH_DEC;
            nxt.year      = YEAR_W'(YEAR_LIMIT);
            nxt.mod400    = LIMIT_MOD;
            flags.finish  = 1'b1;
            flags.clamped = 1'b1;
          end else begin
            nxt.month  = MONTH_JAN;
            nxt.year   = cur.year + YEAR_W'(1);
            nxt.mod400 = (cur.mod400 == MOD_LAST) ? '0 : cur.mod400 + MOD400_W'(1);
          end
        end else begin
          nxt.month = cur.month + MONTH_W'(1);
        end
      end
    end else begin
      if (left_ext < CW'(cur.day)) begin
        nxt.day      = cur.day - left_ext[DAY_W-1:0];
        flags.finish = 1'b1;
      end else begin
        left_next = LEFT_W'(left_ext - CW'(cur.day));
        if (cur.month == MONTH_JAN) begin
          if (cur.year <= YEAR_W'(1)) begin
            nxt.day       = DAY_FIRST;
            nxt.month     = MONTH_JAN;
            nxt.year      = YEAR_W'(1);
            nxt.mod400    = MOD400_W'(1);
            flags.finish  = 1'b1;
            flags.clamped = 1'b1;
          end else begin
            nxt.day    = DAY_LAST;
            nxt.month  = MONTH_DEC;
            nxt.year   = cur.year - YEAR_W'(1);
            nxt.mod400 = (cur.mod400 == '0) ? MOD_LAST : cur.mod400 - MOD400_W'(1);
          end
        end else begin
          nxt.month = prev_month;
          nxt.day   = ml_prev;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;
  import cds_pkg::*;

  // The fourth command code has no meaning; the block answers with the held date.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int NUM_RANDOM   = 1800;
  localparam int HOLD_AT      = 300;  // response count at which the receiver holds off
  localparam int HOLD_CYCLES  = 400;
  localparam int PAUSE_AT     = 900;  // request index at which the sender drains the block
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [STATUS_W-1:0] status;
  } date_word_t;

  // One row of the directed table. Where typed is set, want is the response
  // read straight off the calendar rules; otherwise the predictor decides.
  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [DAY_W-1:0]       day;
    logic [MONTH_W-1:0]     month;
    logic [YEAR_W-1:0]      year;
    logic [STEP_DAYS_W-1:0] days;
    logic                   typed;
    date_word_t             want;
  } stim_row_t;

  localparam date_word_t NO_CHECK = '0;
  localparam int NUM_DIRECTED = 25;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cds_req_if req ();
  cds_rsp_if rsp ();

  calendar_date_stepper_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // 10-unit clock period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the date the block should be holding.
  int unsigned held_day   = 1;
  int unsigned held_month = 1;
  int unsigned held_year  = 1;

  date_word_t pending_dates[$];
  int         mismatch_count = 0;
  int         got_count      = 0;
  bit         sender_burst   = 1'b0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // Reset date, unused command, and a step below the lower limit.
    '{CMD_UNUSED, 5'd0,  4'd0,  14'd0,     16'd0,     1'b1, '{5'd1, 4'd1, 14'd1, STATUS_OK}},
    '{CMD_BWD,    5'd0,  4'd0,  14'd0,     16'd1,     1'b1, '{5'd1, 4'd1, 14'd1, STATUS_CLAMPED}},
    '{CMD_FWD,    5'd0,  4'd0,  14'd0,     16'd0,     1'b1, '{5'd1, 4'd1, 14'd1, STATUS_OK}},
    // Rejected loads: the held date stays put.
    '{CMD_LOAD,   5'd29, 4'd2,  14'd1,     16'd0,     1'b1, '{5'd1, 4'd1, 14'd1, STATUS_BAD_LOAD}},
    '{CMD_LOAD,   5'd0,  4'd1,  14'd1,     16'd0,     1'b1, '{5'd1, 4'd1, 14'd1, STATUS_BAD_LOAD}},
    '{CMD_LOAD,   5'd1,  4'd0,  14'd1,     16'd0,     1'b1, '{5'd1, 4'd1, 14'd1, STATUS_BAD_LOAD}},
    '{CMD_LOAD,   5'd1,  4'd13, 14'd1,     16'd0,     1'b1, '{5'd1, 4'd1, 14'd1, STATUS_BAD_LOAD}},
    '{CMD_LOAD,   5'd31, 4'd15, 14'd16383, 16'd65535, 1'b1, '{5'd1, 4'd1, 14'd1, STATUS_BAD_LOAD}},
    '{CMD_LOAD,   5'd1,  4'd1,  14'd0,     16'd0,     1'b1, '{5'd1, 4'd1, 14'd1, STATUS_BAD_LOAD}},
    '{CMD_LOAD,   5'd1,  4'd1,  14'd10001, 16'd0,     1'b1, '{5'd1, 4'd1, 14'd1, STATUS_BAD_LOAD}},
    '{CMD_LOAD,   5'd31, 4'd4,  14'd2001,  16'd0,     1'b1, '{5'd1, 4'd1, 14'd1, STATUS_BAD_LOAD}},
    // Leap days: by 400 yes, by 100 no, by 4 yes.
    '{CMD_LOAD,   5'd29, 4'd2,  14'd2000,  16'd0,     1'b1, '{5'd29, 4'd2, 14'd2000, STATUS_OK}},
    '{CMD_LOAD,   5'd29, 4'd2,  14'd1900,  16'd0,     1'b1,
      '{5'd29, 4'd2, 14'd2000, STATUS_BAD_LOAD}},
    '{CMD_LOAD,   5'd29, 4'd2,  14'd2024,  16'd0,     1'b1, '{5'd29, 4'd2, 14'd2024, STATUS_OK}},
    '{CMD_FWD,    5'd0,  4'd0,  14'd0,     16'd1,     1'b0, NO_CHECK},
    '{CMD_BWD,    5'd0,  4'd0,  14'd0,     16'd1,     1'b0, NO_CHECK},
    '{CMD_FWD,    5'd0,  4'd0,  14'd0,     16'd365,   1'b0, NO_CHECK},
    // Upper limit.
    '{CMD_LOAD,   5'd31, 4'd12, 14'd10000, 16'd0,     1'b1,
      '{5'd31, 4'd12, 14'd10000, STATUS_OK}},
    '{CMD_FWD,    5'd0,  4'd0,  14'd0,     16'd1,     1'b1,
      '{5'd31, 4'd12, 14'd10000, STATUS_CLAMPED}},
    '{CMD_FWD,    5'd0,  4'd0,  14'd0,     16'd65535, 1'b1,
      '{5'd31, 4'd12, 14'd10000, STATUS_CLAMPED}},
    '{CMD_BWD,    5'd0,  4'd0,  14'd0,     16'd65535, 1'b0, NO_CHECK},
    // Lower limit with the largest step.
    '{CMD_LOAD,   5'd1,  4'd1,  14'd1,     16'd0,     1'b1, '{5'd1, 4'd1, 14'd1, STATUS_OK}},
    '{CMD_BWD,    5'd0,  4'd0,  14'd0,     16'd65535, 1'b1, '{5'd1, 4'd1, 14'd1, STATUS_CLAMPED}},
    '{CMD_FWD,    5'd0,  4'd0,  14'd0,     16'd65535, 1'b0, NO_CHECK},
    '{CMD_UNUSED, 5'd31, 4'd15, 14'd16383, 16'd65535, 1'b0, NO_CHECK}
  };

  function automatic bit leap_year(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Apply one request word to the predicted date and return the response word.
  function automatic date_word_t step_calendar(logic [CMD_W-1:0] cmd, int unsigned ld,
                                               int unsigned lm, int unsigned ly,
                                               logic [STEP_DAYS_W-1:0] days);
    longint unsigned     left;
    int unsigned         room;
    logic [STATUS_W-1:0] st;
    date_word_t          word;
    st   = STATUS_OK;
    left = longint'(days) & ((longint'(1) << STEP_WIDTH_DEFAULT) - 1);
    case (cmd)
      CMD_LOAD: begin
        if (lm < 1 || lm > 12 || ly < 1 || ly > YEAR_LIMIT_DEFAULT ||
            ld < 1 || ld > days_in_month(lm, ly)) begin
          st = STATUS_BAD_LOAD;
        end else begin
          held_day   = ld;
          held_month = lm;
          held_year  = ly;
        end
      end
      CMD_FWD: begin
        while (left > 0 && st == STATUS_OK) begin
          room = days_in_month(held_month, held_year) - held_day;
          if (left <= room) begin
            held_day += int'(left);
            left = 0;
          end else begin
            left -= room + 1;
            held_day = 1;
            if (held_month == 12) begin
              if (held_year >= YEAR_LIMIT_DEFAULT) begin
                held_day   = 31;
                held_month = 12;
                held_year  = YEAR_LIMIT_DEFAULT;
                st = STATUS_CLAMPED;
              end else begin
                held_month = 1;
                held_year++;
              end
            end else begin
              held_month++;
            end
          end
        end
      end
      CMD_BWD: begin
        while (left > 0 && st == STATUS_OK) begin
          if (left < held_day) begin
            held_day -= int'(left);
            left = 0;
          end else begin
            left -= held_day;
            if (held_month == 1) begin
              if (held_year <= 1) begin
                held_day   = 1;
                held_month = 1;
                held_year  = 1;
                st = STATUS_CLAMPED;
              end else begin
                held_month = 12;
                held_year--;
                held_day = days_in_month(held_month, held_year);
              end
            end else begin
              held_month--;
              held_day = days_in_month(held_month, held_year);
            end
          end
        end
      end
      default: ;
    endcase
    word.day    = DAY_W'(held_day);
    word.month  = MONTH_W'(held_month);
    word.year   = YEAR_W'(held_year);
    word.status = st;
    return word;
  endfunction

  // Offer one request word. Called at a falling edge and returns at a falling
  // edge with valid still high, so back-to-back words never lower and raise
  // valid in the same step.
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [DAY_W-1:0] day,
                           logic [MONTH_W-1:0] month, logic [YEAR_W-1:0] year,
                           logic [STEP_DAYS_W-1:0] days, logic typed, date_word_t want);
    int         gap;
    date_word_t predicted;
    gap = sender_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.cmd        <= cmd;
    req.load_day   <= day;
    req.load_month <= month;
    req.load_year  <= year;
    req.step_days  <= days;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    // Word accepted at this edge: run the predictor and queue the response.
    predicted = step_calendar(cmd, day, month, year, days);
    pending_dates.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Stimulus: reset, directed table, random words with a drain pause midway.
  initial begin : stimulus
    logic [CMD_W-1:0]       r_cmd;
    logic [DAY_W-1:0]       r_day;
    logic [MONTH_W-1:0]     r_month;
    logic [YEAR_W-1:0]      r_year;
    logic [STEP_DAYS_W-1:0] r_days;
    int                     pick;
    int                     sub;
    int unsigned            m;
    int unsigned            y;

    req.valid      <= 1'b0;
    req.cmd        <= CMD_LOAD;
    req.load_day   <= '0;
    req.load_month <= '0;
    req.load_year  <= '0;
    req.step_days  <= '0;

    // Hold reset, then release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_word(directed_rows[i].cmd, directed_rows[i].day, directed_rows[i].month,
                directed_rows[i].year, directed_rows[i].days, directed_rows[i].typed,
                directed_rows[i].want);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // Run the sender without gaps in every fourth stretch of 150 words.
      sender_burst = ((n / 150) % 4) == 3;

      // Drain the block once: drop valid and wait for every response.
      if (n == PAUSE_AT) begin
        req.valid <= 1'b0;
        do @(negedge clk); while (pending_dates.size() != 0);
      end

      // Start from noise in every field so unused fields toggle too.
      r_cmd   = CMD_W'($urandom);
      r_day   = DAY_W'($urandom);
      r_month = MONTH_W'($urandom);
      r_year  = YEAR_W'($urandom);

      // Keep most moves short; a few use the full step range.
      pick = $urandom_range(0, 99);
      if (pick < 50)      r_days = STEP_DAYS_W'($urandom_range(0, 40));
      else if (pick < 75) r_days = STEP_DAYS_W'($urandom_range(0, 1000));
      else if (pick < 90) r_days = STEP_DAYS_W'($urandom_range(0, 10000));
      else                r_days = STEP_DAYS_W'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        r_cmd = CMD_LOAD;
        sub = $urandom_range(0, 9);
        if (sub <= 7) begin
          // Well-formed date; some near the year limits so moves clamp.
          m = $urandom_range(1, 12);
          if (sub <= 5)       y = $urandom_range(1, YEAR_LIMIT_DEFAULT);
          else if (sub == 6)  y = $urandom_range(1, 3);
          else                y = $urandom_range(YEAR_LIMIT_DEFAULT - 2, YEAR_LIMIT_DEFAULT);
          r_month = MONTH_W'(m);
          r_year  = YEAR_W'(y);
          r_day   = DAY_W'($urandom_range(1, days_in_month(m, y)));
        end else if (sub == 8) begin
          // Leap day on a multiple of 4 or of 100.
          y = $urandom_range(0, 1) ? 4 * $urandom_range(1, 2500) : 100 * $urandom_range(1, 100);
          r_month = MONTH_FEB;
          r_year  = YEAR_W'(y);
          r_day   = 5'd29;
        end
      end else if (pick < 55) begin
        r_cmd = CMD_FWD;
      end else if (pick < 95) begin
        r_cmd = CMD_BWD;
      end else begin
        r_cmd = CMD_UNUSED;
      end

      send_word(r_cmd, r_day, r_month, r_year, r_days, 1'b0, NO_CHECK);
    end
    req.valid <= 1'b0;

    // Wait out every response, then a tail to catch stray words.
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("** calendar_date_stepper_core: PASSED **");
    end else begin
      $display("** calendar_date_stepper_core: FAILED **");
    end
    $finish;
  end

  // Response side: random stalls, burst stretches, one long hold-off that
  // backs the block up into its request port.
  initial begin : response_check
    int         stall;
    date_word_t want;
    rsp.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (got_count == HOLD_AT) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = (((got_count / 170) % 4) == 1) ? 0 : $urandom_range(0, 3);
        if (stall > 0) begin
          rsp.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      // Compare the word against the oldest prediction.
      if (pending_dates.size() == 0) begin
        $error("response word with no pending date: day %0d month %0d year %0d status %0d",
               rsp.out_day, rsp.out_month, rsp.out_year, rsp.status);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        if (rsp.out_day !== want.day) begin
          $error("out_day: expected %0d, got %0d", want.day, rsp.out_day);
          mismatch_count++;
        end
        if (rsp.out_month !== want.month) begin
          $error("out_month: expected %0d, got %0d", want.month, rsp.out_month);
          mismatch_count++;
        end
        if (rsp.out_year !== want.year) begin
          $error("out_year: expected %0d, got %0d", want.year, rsp.out_year);
          mismatch_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatch_count++;
        end
      end
      got_count++;
      @(negedge clk);
    end
  end

  // Hang guard: far beyond a run where every word takes the longest move.
  initial begin : watchdog
    #150_000_000;
    $display("** calendar_date_stepper_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

FILE: calendar_date_stepper_core.f
rtl/cds_pkg.sv
rtl/cds_req_if.sv
rtl/cds_rsp_if.sv
rtl/cds_step_unit.sv
rtl/calendar_date_stepper_core.sv
tb/sv/tb.sv
